[src/tscc_pkg.sv]
// Shared types and constants of the trajectory speed consistency checker.
`default_nettype none

package tscc_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_MIN_SPEED = 2'd0;
	localparam logic [1:0] REG_MIN_STEP  = 2'd1;
	localparam logic [1:0] REG_TOL_PCT   = 2'd2;
	localparam logic [1:0] REG_TOL_CAP   = 2'd3;

	// Verdict codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_STEP  = 2'd1;
	localparam logic [1:0] STAT_SPEED = 2'd2;

	// Pair classes decided in the front end
	localparam logic [1:0] CLS_PASS  = 2'd0;
	localparam logic [1:0] CLS_STEP  = 2'd1;
	localparam logic [1:0] CLS_ARITH = 2'd2;

	// (200 * 1e6)^2: scales squared displacement to the speed comparison
	localparam logic [55:0] SCALE = 56'd40000000000000000;

	localparam int unsigned FIFO_DEPTH = 2;

	typedef struct packed {
		logic [16:0] min_speed;
		logic [19:0] min_step;
		logic [6:0]  tol_pct;
		logic [16:0] tol_cap;
	} tscc_cfg_t;

	typedef struct packed {
		logic        first;
		logic        check;
		logic [1:0]  cls;
		logic [7:0]  idx;
		logic        last;
		logic [31:0] ux;
		logic [31:0] uy;
		logic [31:0] dt;
		logic [25:0] c_hi;
		logic [25:0] c_lo;
		logic        a_gt_b;
	} tscc_item_t;

endpackage

`default_nettype wire

[src/trajectory_speed_consistency_check_top.sv]
// Top level of the trajectory speed consistency checker.
//
//  Channel   Ports                 Beat
//  -------   -------------------   -----------------------------------------------
//  points    s_axis_*              tdata: pos_x, pos_y, time_us, speed_mm_s
//                                  tuser: first_point, stationary; tlast: last_point
//  verdicts  m_axis_*              tdata: status, fail_index; tlast: done_res
//  config    cfg_wr_en/addr/wdata  one register per write, no read-back
//
//  A point passes front-end stages 1 and 2 into the queue; one that needs the speed
//  compare holds the back end for 18 partial products on the shared 32x32 multiplier
//  (cut short when the upper bound already fails); all others are settled as they leave the queue.
//  Reset loads the register defaults and zeroes the trajectory state and verdict.
//  m_axis_tready low holds the result register; the queue then fills and
//  s_axis_tready drops.
`default_nettype none

module trajectory_speed_consistency_check_top import tscc_pkg::*; #(
	parameter int MAX_POINTS = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [19:0]  cfg_wdata,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [119:0] s_axis_tdata,  // pos_x, pos_y, time_us, speed_mm_s, zero pad
	input  wire logic [1:0]   s_axis_tuser,  // first_point, stationary
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // status, fail_index, zero pad
	output logic              m_axis_tlast
);

	tscc_cfg_t  cfg_q;
	tscc_item_t push_item, head_item;
	logic       push, q_full, q_pop, q_empty;
	logic [1:0] status;
	logic [7:0] fail_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_speed <= 17'd1000;
			cfg_q.min_step  <= 20'd1000;
			cfg_q.tol_pct   <= 7'd20;
			cfg_q.tol_cap   <= 17'd1000;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_MIN_SPEED: cfg_q.min_speed <= cfg_wdata[16:0];
				REG_MIN_STEP:  cfg_q.min_step  <= cfg_wdata;
				REG_TOL_PCT:   cfg_q.tol_pct   <= cfg_wdata[6:0];
				REG_TOL_CAP:   cfg_q.tol_cap   <= cfg_wdata[16:0];
				default: begin
				end
			endcase
		end
	end

	tscc_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.first_point(s_axis_tuser[0]),
		.stationary (s_axis_tuser[1]),
		.pos_x      (s_axis_tdata[31:0]),
		.pos_y      (s_axis_tdata[63:32]),
		.time_us    (s_axis_tdata[95:64]),
		.speed_mm_s (s_axis_tdata[113:96]),
		.last_point (s_axis_tlast),
		.q_full     (q_full),
		.push       (push),
		.item       (push_item)
	);

	tscc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_item(push_item),
		.full   (q_full),
		.pop    (q_pop),
		.rd_item(head_item),
		.empty  (q_empty)
	);

	tscc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_status(status),
		.out_index (fail_index),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, fail_index, status};

endmodule

`default_nettype wire

[src/tscc_front.sv]
// Front end: accepts points, tracks the trajectory and classifies each pair.
`default_nettype none

module tscc_front import tscc_pkg::*; #(
	parameter int MAX_POINTS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tscc_cfg_t   cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        first_point,
	input  wire logic        stationary,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] time_us,
	input  wire logic [17:0] speed_mm_s,
	input  wire logic        last_point,
	input  wire logic        q_full,
	output logic             push,
	output tscc_item_t       item
);

	localparam int IDX_CAP = (MAX_POINTS - 1 > 255) ? 255 : MAX_POINTS - 1;
	localparam logic [7:0] IDX_MAX = IDX_CAP[7:0];

	logic        beat;
	logic        rdy1, rdy2;
	logic [7:0]  idx_nxt;

	logic [31:0] prev_x_q, prev_y_q, prev_t_q;
	logic [17:0] prev_v_q;
	logic [7:0]  idx_q;
	logic        skip_q;

	logic        v_s1;
	logic [32:0] dx_s1, dy_s1, dt_s1;
	logic [18:0] sp_s1;
	logic        first_s1, check_s1, last_s1;
	logic [7:0]  idx_s1;

	logic        v_s2;
	logic [31:0] ux_s2, uy_s2, dt_s2;
	logic [1:0]  cls_s2;
	logic [24:0] a_s2, bp_s2, bc_s2;
	logic        first_s2, check_s2, last_s2;
	logic [7:0]  idx_s2;

	logic [32:0] dx_neg, dy_neg;
	logic        below, nonpos, short_step;
	logic [1:0]  cls;
	logic [24:0] b_min;

	assign rdy2     = !v_s2 || !q_full;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign beat     = in_valid && in_ready;

	always_comb begin
		if (first_point) begin
			idx_nxt = '0;
		end else if (idx_q < IDX_MAX) begin
			idx_nxt = idx_q + 8'd1;
		end else begin
			idx_nxt = idx_q;
		end
	end

	// Trajectory state and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_t_q <= '0;
			prev_v_q <= '0;
			idx_q    <= '0;
			skip_q   <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (beat) begin
				prev_x_q <= pos_x;
				prev_y_q <= pos_y;
				prev_t_q <= time_us;
				prev_v_q <= speed_mm_s;
				idx_q    <= idx_nxt;
				if (first_point) begin
					skip_q <= stationary;
				end
			end
			if (rdy1) begin
				v_s1 <= beat;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1: differences against the previous point
	always_ff @(posedge clk) begin
		if (rdy1 && beat) begin
			dx_s1    <= {pos_x[31], pos_x} - {prev_x_q[31], prev_x_q};
			dy_s1    <= {pos_y[31], pos_y} - {prev_y_q[31], prev_y_q};
			dt_s1    <= {1'b0, time_us} - {1'b0, prev_t_q};
			sp_s1    <= {speed_mm_s[17], speed_mm_s} + {prev_v_q[17], prev_v_q};
			first_s1 <= first_point;
			check_s1 <= !first_point && !skip_q;
			idx_s1   <= idx_nxt;
			last_s1  <= last_point;
		end
	end

	assign dx_neg     = -dx_s1;
	assign dy_neg     = -dy_s1;
	assign below      = $signed({sp_s1[18], sp_s1}) < $signed({2'b00, cfg.min_speed, 1'b0});
	assign nonpos     = dt_s1[32] || (dt_s1 == '0);
	assign short_step = dt_s1[31:0] < {12'd0, cfg.min_step};

	always_comb begin
		if (below) begin
			cls = CLS_PASS;
		end else if (nonpos || short_step) begin
			cls = CLS_STEP;
		end else begin
			cls = CLS_ARITH;
		end
	end

	// Stage 2: magnitudes, class and tolerance terms
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ux_s2    <= dx_s1[32] ? dx_neg[31:0] : dx_s1[31:0];
			uy_s2    <= dy_s1[32] ? dy_neg[31:0] : dy_s1[31:0];
			dt_s2    <= dt_s1[31:0];
			cls_s2   <= cls;
			a_s2     <= {7'd0, sp_s1[17:0]} * 25'd100;
			bp_s2    <= {7'd0, sp_s1[17:0]} * {18'd0, cfg.tol_pct};
			bc_s2    <= {8'd0, cfg.tol_cap} * 25'd200;
			first_s2 <= first_s1;
			check_s2 <= check_s1;
			idx_s2   <= idx_s1;
			last_s2  <= last_s1;
		end
	end

	assign b_min = (bc_s2 < bp_s2) ? bc_s2 : bp_s2;
	assign push  = v_s2 && !q_full;

	always_comb begin
		item.first  = first_s2;
		item.check  = check_s2;
		item.cls    = cls_s2;
		item.idx    = idx_s2;
		item.last   = last_s2;
		item.ux     = ux_s2;
		item.uy     = uy_s2;
		item.dt     = dt_s2;
		item.c_hi   = {1'b0, a_s2} + {1'b0, b_min};
		item.c_lo   = {1'b0, a_s2} - {1'b0, b_min};
		item.a_gt_b = a_s2 > b_min;
	end

endmodule

`default_nettype wire

[src/tscc_fifo.sv]
// Short queue of classified items between front and back end.
`default_nettype none

module tscc_fifo import tscc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire tscc_item_t wr_item,
	output logic            full,
	input  wire logic       pop,
	output tscc_item_t      rd_item,
	output logic            empty
);

	localparam int AW = $clog2(FIFO_DEPTH);

	tscc_item_t    mem_q [FIFO_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = cnt_q == (AW + 1)'(FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

[src/tscc_back.sv]
// Back end: latched verdict, shared multiplier sequence and result register.
`default_nettype none

module tscc_back import tscc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire tscc_item_t q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      out_status,
	output logic [7:0]      out_index,
	output logic            out_last
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_BUSY = 2'd1;
	localparam logic [1:0] B_DONE = 2'd2;

	localparam logic [1:0] DST_NONE = 2'd0;
	localparam logic [1:0] DST_ACC  = 2'd1;
	localparam logic [1:0] DST_KH   = 2'd2;
	localparam logic [1:0] DST_KL   = 2'd3;

	// Multiply schedule
	localparam logic [4:0] SQ_UX   = 5'd0;
	localparam logic [4:0] SQ_UY   = 5'd1;
	localparam logic [4:0] SQ_KH   = 5'd2;
	localparam logic [4:0] SQ_KL   = 5'd3;
	localparam logic [4:0] SQ_L00  = 5'd4;
	localparam logic [4:0] SQ_L01  = 5'd5;
	localparam logic [4:0] SQ_L10  = 5'd6;
	localparam logic [4:0] SQ_L11  = 5'd7;
	localparam logic [4:0] SQ_L20  = 5'd8;
	localparam logic [4:0] SQ_L21  = 5'd9;
	localparam logic [4:0] SQ_H00  = 5'd10;
	localparam logic [4:0] SQ_H01  = 5'd11;
	localparam logic [4:0] SQ_H10  = 5'd12;
	localparam logic [4:0] SQ_H11  = 5'd13;
	localparam logic [4:0] SQ_W00  = 5'd14;
	localparam logic [4:0] SQ_W01  = 5'd15;
	localparam logic [4:0] SQ_W10  = 5'd16;
	localparam logic [4:0] SQ_W11  = 5'd17;
	localparam logic [4:0] SQ_GAP  = 5'd18;
	localparam logic [4:0] SQ_LAST = 5'd19;

	logic [1:0]   state_q;
	logic [4:0]   step_q;
	tscc_item_t   it_q;
	logic [64:0]  q_q;
	logic [127:0] l_q, acc_q;
	logic [57:0]  kh_q, kl_q;
	logic [63:0]  prod_s1;
	logic [1:0]   dst_s1, sh_s1;
	logic         clr_s1;
	logic [1:0]   res_q;
	logic [1:0]   verdict_q;
	logic [7:0]   failed_q;
	logic         out_valid_q;
	logic [1:0]   out_status_q;
	logic [7:0]   out_index_q;
	logic         out_last_q;

	logic [31:0]  op_a, op_b;
	logic [1:0]   dst, sh;
	logic         clr;
	logic         hi_fail, lo_fail;
	logic         out_free, emit, start;
	logic [1:0]   nv;
	logic [7:0]   nf;
	logic         nl;
	logic [127:0] acc_base, addend;

	assign out_free = !out_valid_q || out_ready;
	assign hi_fail  = l_q > acc_q;
	assign lo_fail  = it_q.a_gt_b && (l_q < acc_q);

	always_comb begin
		op_a = '0;
		op_b = '0;
		dst  = DST_NONE;
		sh   = 2'd0;
		clr  = 1'b0;
		case (step_q)
			SQ_UX: begin
				op_a = it_q.ux; op_b = it_q.ux; dst = DST_ACC; clr = 1'b1;
			end
			SQ_UY: begin
				op_a = it_q.uy; op_b = it_q.uy; dst = DST_ACC;
			end
			SQ_KH: begin
				op_a = {6'd0, it_q.c_hi}; op_b = it_q.dt; dst = DST_KH;
			end
			SQ_KL: begin
				op_a = {6'd0, it_q.c_lo}; op_b = it_q.dt; dst = DST_KL;
			end
			SQ_L00: begin
				op_a = q_q[31:0]; op_b = SCALE[31:0]; dst = DST_ACC; clr = 1'b1;
			end
			SQ_L01: begin
				op_a = q_q[31:0]; op_b = {8'd0, SCALE[55:32]}; dst = DST_ACC; sh = 2'd1;
			end
			SQ_L10: begin
				op_a = q_q[63:32]; op_b = SCALE[31:0]; dst = DST_ACC; sh = 2'd1;
			end
			SQ_L11: begin
				op_a = q_q[63:32]; op_b = {8'd0, SCALE[55:32]}; dst = DST_ACC; sh = 2'd2;
			end
			SQ_L20: begin
				op_a = {31'd0, q_q[64]}; op_b = SCALE[31:0]; dst = DST_ACC; sh = 2'd2;
			end
			SQ_L21: begin
				op_a = {31'd0, q_q[64]}; op_b = {8'd0, SCALE[55:32]}; dst = DST_ACC;
				sh = 2'd3;
			end
			SQ_H00: begin
				op_a = kh_q[31:0]; op_b = kh_q[31:0]; dst = DST_ACC; clr = 1'b1;
			end
			SQ_H01: begin
				op_a = kh_q[31:0]; op_b = {6'd0, kh_q[57:32]}; dst = DST_ACC; sh = 2'd1;
			end
			SQ_H10: begin
				op_a = {6'd0, kh_q[57:32]}; op_b = kh_q[31:0]; dst = DST_ACC; sh = 2'd1;
			end
			SQ_H11: begin
				op_a = {6'd0, kh_q[57:32]}; op_b = {6'd0, kh_q[57:32]}; dst = DST_ACC;
				sh = 2'd2;
			end
			SQ_W00: begin
				op_a = kl_q[31:0]; op_b = kl_q[31:0]; dst = DST_ACC; clr = 1'b1;
			end
			SQ_W01: begin
				op_a = kl_q[31:0]; op_b = {6'd0, kl_q[57:32]}; dst = DST_ACC; sh = 2'd1;
			end
			SQ_W10: begin
				op_a = {6'd0, kl_q[57:32]}; op_b = kl_q[31:0]; dst = DST_ACC; sh = 2'd1;
			end
			SQ_W11: begin
				op_a = {6'd0, kl_q[57:32]}; op_b = {6'd0, kl_q[57:32]}; dst = DST_ACC;
				sh = 2'd2;
			end
			default: begin
			end
		endcase
		if (state_q != B_BUSY) begin
			dst = DST_NONE;
		end
	end

	always_comb begin
		q_pop = 1'b0;
		emit  = 1'b0;
		start = 1'b0;
		nv    = verdict_q;
		nf    = failed_q;
		nl    = q_head.last;
		case (state_q)
			B_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					if (q_head.first) begin
						nv   = STAT_OK;
						nf   = '0;
						emit = 1'b1;
					end else if (q_head.check && verdict_q == STAT_OK) begin
						case (q_head.cls)
							CLS_STEP: begin
								nv   = STAT_STEP;
								nf   = q_head.idx;
								emit = 1'b1;
							end
							CLS_ARITH: begin
								start = 1'b1;
							end
							default: begin
								emit = 1'b1;
							end
						endcase
					end else begin
						emit = 1'b1;
					end
				end
			end
			B_DONE: begin
				nl = it_q.last;
				if (out_free) begin
					emit = 1'b1;
					if (res_q != STAT_OK) begin
						nv = res_q;
						nf = it_q.idx;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			verdict_q   <= STAT_OK;
			failed_q    <= '0;
			out_valid_q <= 1'b0;
			dst_s1      <= DST_NONE;
		end else begin
			dst_s1 <= dst;
			if (emit) begin
				verdict_q   <= nv;
				failed_q    <= nf;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (start) begin
						state_q <= B_BUSY;
						step_q  <= SQ_UX;
					end
				end
				B_BUSY: begin
					if ((step_q == SQ_W01 && hi_fail) || step_q == SQ_LAST) begin
						state_q <= B_DONE;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign acc_base = clr_s1 ? '0 : acc_q;
	assign addend   = 128'(prod_s1) << {sh_s1, 5'd0};

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		sh_s1   <= sh;
		clr_s1  <= clr;
		case (dst_s1)
			DST_ACC: acc_q <= acc_base + addend;
			DST_KH:  kh_q  <= prod_s1[57:0];
			DST_KL:  kl_q  <= prod_s1[57:0];
			default: begin
			end
		endcase
		if (start) begin
			it_q <= q_head;
		end
		if (state_q == B_BUSY && step_q == SQ_KL) begin
			q_q <= acc_q[64:0];
		end
		if (state_q == B_BUSY && step_q == SQ_H01) begin
			l_q <= acc_q;
		end
		if (state_q == B_BUSY && step_q == SQ_W01) begin
			res_q <= hi_fail ? STAT_SPEED : STAT_OK;
		end
		if (state_q == B_BUSY && step_q == SQ_LAST) begin
			res_q <= lo_fail ? STAT_SPEED : STAT_OK;
		end
		if (emit) begin
			out_status_q <= nv;
			out_index_q  <= nf;
			out_last_q   <= nl;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_index  = out_index_q;
	assign out_last   = out_last_q;

endmodule

`default_nettype wire
